@@ sv/mts_pkg.sv @@
// ----------------------------------------------------------------------------
// mts_pkg: shared constants and table builder for the multi-tone synthesizer
// Register map codes, mixing constants and the quarter-wave sine generator.
// ----------------------------------------------------------------------------
package mts_pkg;

  // APB register map: byte address = 4 * index
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_TONE_COUNT  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TONE_STEP_0 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TONE_STEP_3 = 3'd4;

  localparam int unsigned COUNT_W = 3;
  localparam int unsigned STEP_W  = 31;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd1;
  localparam logic [STEP_W-1:0]  STEP_RESET  = 31'd97391549;

  // 0.999 in Q15
  localparam int unsigned    SCALE_W   = 15;
  localparam logic [14:0]    SCALE_Q15 = 15'd32735;

  // pi in Q30 and the Taylor divisors (2k)(2k+1)
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210};

  // Quarter-wave entry: round(amp * sin(pi/2 * (2i+1) / 2^(abits+1))),
  // Q30 Taylor series, clamped to 0 .. amp. Elaboration only.
  function automatic logic [23:0] quarter_entry(input int unsigned idx,
                                                input int unsigned abits,
                                                input int unsigned sbits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] amp;
    logic signed [63:0] v;
    amp  = (64'sd1 <<< (sbits - 1)) - 64'sd1;
    x    = (PI_Q30 * 64'(2 * idx + 1)) >> (abits + 2);
    x2   = (x * x) >> 30;
    sum  = $signed(x);
    term = x;
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k];
      if (k % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    v = (sum * amp + (64'sd1 <<< 29)) >>> 30;
    if (v > amp) begin
      v = amp;
    end
    return v[23:0];
  endfunction

endpackage

@@ sv/mts_if.sv @@
// ----------------------------------------------------------------------------
// mts_if: valid/ready channels of the multi-tone synthesizer
// Request channel carries the restart flag, sample channel the mixed sample.
// ----------------------------------------------------------------------------
interface mts_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface mts_smp_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

@@ sv/mts_sine_rom.sv @@
// ----------------------------------------------------------------------------
// mts_sine_rom: quarter-wave sine table with registered read
// Contents are built at elaboration; magnitudes 0 .. 2^(SAMPLE_BITS-1)-1.
// ----------------------------------------------------------------------------
module mts_sine_rom #(
  parameter int TABLE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                       clk_i,
  input  logic [TABLE_ADDR_BITS-1:0] addr_i,
  output logic [SAMPLE_BITS-2:0]     data_o
);
  import mts_pkg::*;

  localparam int QLEN = 1 << TABLE_ADDR_BITS;

  typedef logic [SAMPLE_BITS-2:0] entry_t;
  typedef entry_t rom_t [QLEN];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < QLEN; i++) begin
      r[i] = entry_t'(quarter_entry(i, TABLE_ADDR_BITS, SAMPLE_BITS));
    end
    return r;
  endfunction

  localparam rom_t QUARTER = build_rom();

  logic [SAMPLE_BITS-2:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= QUARTER[addr_i];
  end

  assign data_o = data_q;

endmodule

@@ sv/multi_tone_sine_synthesizer.sv @@
// ----------------------------------------------------------------------------
// multi_tone_sine_synthesizer: DDS mixer of up to NUM_TONES sine tones
// One request -> one sample: sum of active tone sines * 0.999 / tone count.
// ----------------------------------------------------------------------------
// From request accept to sample valid: for each of the N active tones a
//   lookup through the registered sine ROM (ST_LOOK) and an add (ST_ACC), then the
//   scale multiply, rounding add, then one quotient bit per cycle in the
//   restoring divider by N; ST_EMIT holds the sample until the output is free.
// A request is taken only in ST_IDLE; not ready while busy.
// Reset: async active low; phases zero, tone_count 1, all steps 1 kHz.
// ----------------------------------------------------------------------------
module multi_tone_sine_synthesizer #(
  parameter int NUM_TONES       = 4,
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mts_req_if.sink                       req_i,
  mts_smp_if.source                     smp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mts_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import mts_pkg::*;

  // --------------------------------------------------------------------------
  // Widths
  // --------------------------------------------------------------------------
  localparam int TONE_W     = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1;
  localparam int STEP_SHIFT = 32 - PHASE_BITS;
  localparam int SUM_W      = SAMPLE_BITS + 3;      // +-7 * AMP
  localparam int MAG_W      = SUM_W - 1;
  localparam int PROD_W     = MAG_W + SCALE_W;
  localparam int QUO_W      = PROD_W + 1 - 15;      // (prod + round) >> 15
  localparam int BIT_W      = $clog2(QUO_W + 1);

  localparam logic [SAMPLE_BITS-1:0] AMP = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [COUNT_W-1:0]     NUM_TONES_C = COUNT_W'(NUM_TONES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_ACC,
    ST_SCALE,
    ST_ROUND,
    ST_DIV,
    ST_EMIT
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers (APB, zero wait states)
  // --------------------------------------------------------------------------
  logic [COUNT_W-1:0]   tone_count_q;
  logic [STEP_W-1:0]    tone_step_q [NUM_TONES];
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_count_q <= COUNT_RESET;
      for (int k = 0; k < NUM_TONES; k++) begin
        tone_step_q[k] <= STEP_RESET;
      end
    end else if (cfg_wr) begin
      if (reg_idx == REG_TONE_COUNT) begin
        tone_count_q <= pwdata[COUNT_W-1:0];
      end
      for (int k = 0; k < NUM_TONES; k++) begin
        // step indices past NUM_TONES or REG_TONE_STEP_3 have no storage; writes drop
        if (reg_idx == REG_TONE_STEP_0 + REG_IDX_W'(k) && reg_idx <= REG_TONE_STEP_3) begin
          tone_step_q[k] <= pwdata[STEP_W-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_TONE_COUNT) begin
      prdata = 32'(tone_count_q);
    end
    for (int k = 0; k < NUM_TONES; k++) begin
      if (reg_idx == REG_TONE_STEP_0 + REG_IDX_W'(k) && reg_idx <= REG_TONE_STEP_3) begin
        prdata = 32'(tone_step_q[k]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and datapath
  // --------------------------------------------------------------------------
  state_e                        state_q;
  logic [PHASE_BITS-1:0]         phase_q [NUM_TONES];
  logic [TONE_W-1:0]             tone_q;
  logic [COUNT_W-1:0]            cnt_q;     // effective tone count, 1..NUM_TONES
  logic                          neg_q;     // sign of the pending ROM read
  logic signed [SUM_W-1:0]       acc_q;
  logic                          sign_q;
  logic [PROD_W-1:0]             prod_q;
  logic [QUO_W-1:0]              quo_q;     // dividend in, quotient out
  logic [COUNT_W-1:0]            rem_q;
  logic [BIT_W-1:0]              bit_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;

  logic [COUNT_W-1:0]            cnt_eff;
  logic [PHASE_BITS-1:0]         cur_phase;
  logic [1:0]                    quad;
  logic [TABLE_ADDR_BITS-1:0]    rom_addr;
  logic [SAMPLE_BITS-2:0]        rom_data;
  logic signed [SUM_W-1:0]       rom_ext;
  logic [SUM_W-1:0]              acc_abs;
  logic [PROD_W:0]               rounded;
  logic [COUNT_W:0]              trial;
  logic                          trial_ge;
  logic [SAMPLE_BITS-1:0]        q_lim;
  logic                          out_free;
  logic                          req_fire;

  // tone count zero counts as one, above NUM_TONES as NUM_TONES
  always_comb begin
    if (tone_count_q == '0) begin
      cnt_eff = COUNT_W'(1);
    end else if (tone_count_q > NUM_TONES_C) begin
      cnt_eff = NUM_TONES_C;
    end else begin
      cnt_eff = tone_count_q;
    end
  end

  // phase -> quadrant and quarter-table address
  assign cur_phase = phase_q[tone_q];
  assign quad      = cur_phase[PHASE_BITS-1 -: 2];
  assign rom_addr  = quad[0] ? ~cur_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS]
                             :  cur_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];

  mts_sine_rom #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  assign rom_ext  = $signed({{(SUM_W-SAMPLE_BITS+1){1'b0}}, rom_data});
  assign acc_abs  = acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);

  // round-half-up: floor((m + d/2) / d), d = N * 2^15; the 2^15 drops as a shift
  assign rounded  = {1'b0, prod_q} + ((PROD_W+1)'(cnt_q) << 14);

  // restoring divider, one quotient bit per cycle
  assign trial    = {rem_q, quo_q[QUO_W-1]};
  assign trial_ge = trial >= {1'b0, cnt_q};

  assign q_lim    = (quo_q > QUO_W'(AMP)) ? AMP : SAMPLE_BITS'(quo_q);

  assign out_free = !out_valid_q || smp_o.ready;
  assign req_fire = req_i.valid && req_i.ready;

  assign req_i.ready  = (state_q == ST_IDLE);
  assign smp_o.valid  = out_valid_q;
  assign smp_o.sample = sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tone_q      <= '0;
      cnt_q       <= COUNT_W'(1);
      bit_q       <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NUM_TONES; k++) begin
        phase_q[k] <= '0;
      end
    end else begin
      // in ST_EMIT the output register is reloaded instead
      if (out_valid_q && smp_o.ready && state_q != ST_EMIT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_fire) begin
            if (req_i.restart) begin
              for (int k = 0; k < NUM_TONES; k++) begin
                phase_q[k] <= '0;
              end
            end
            cnt_q   <= cnt_eff;
            tone_q  <= '0;
            acc_q   <= '0;
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          // ROM address presented this cycle; phase read first, then advanced
          neg_q           <= quad[1];
          phase_q[tone_q] <= cur_phase
                           + PHASE_BITS'(tone_step_q[tone_q] >> STEP_SHIFT);
          state_q         <= ST_ACC;
        end
        ST_ACC: begin
          acc_q <= neg_q ? acc_q - rom_ext : acc_q + rom_ext;
          if (COUNT_W'(tone_q) + COUNT_W'(1) == cnt_q) begin
            state_q <= ST_SCALE;
          end else begin
            tone_q  <= tone_q + TONE_W'(1);
            state_q <= ST_LOOK;
          end
        end
        ST_SCALE: begin
          sign_q  <= acc_q[SUM_W-1];
          prod_q  <= PROD_W'(acc_abs[MAG_W-1:0]) * PROD_W'(SCALE_Q15);
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          quo_q   <= rounded[PROD_W:15];
          rem_q   <= '0;
          bit_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q <= trial_ge ? COUNT_W'(trial - {1'b0, cnt_q}) : trial[COUNT_W-1:0];
          quo_q <= {quo_q[QUO_W-2:0], trial_ge};
          bit_q <= bit_q + BIT_W'(1);
          if (bit_q == BIT_W'(QUO_W - 1)) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // hold the result until the output register frees up
          if (out_free) begin
            sample_q    <= sign_q ? -$signed(q_lim) : $signed(q_lim);
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ bench/multi_tone_sine_synthesizer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_tone_sine_synthesizer_tb: self-checking bench for the tone mixer
// Programs tone count and steps over APB and streams restart requests.
// Every sample is checked against an in-bench DDS predictor with its own
// phase state and sine table. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module multi_tone_sine_synthesizer_tb;
  import mts_pkg::*;

  localparam int NUM_TONES       = 4;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int SAMPLE_W        = 16;
  localparam int TABLE_LEN       = 1 << TABLE_ADDR_BITS;
  localparam longint AMP         = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;

  // legal step range: 10 Hz .. 20 kHz
  localparam logic [31:0] STEP_MIN = 32'd973916;
  localparam logic [31:0] STEP_MAX = 32'd1947830973;

  // first index past the register list; writes there must be dropped
  localparam logic [REG_IDX_W-1:0] REG_SPARE_FIRST = REG_TONE_STEP_3 + 3'd1;

  // worst-case request-to-sample latency plus margin for the final drain
  localparam int DRAIN_CYCLES = 2 * NUM_TONES + SAMPLE_W + 16;

  logic clk_i = 1'b0;
  logic rst_ni;

  // config port
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  mts_req_if                         req_if ();
  mts_smp_if #(.SAMPLE_BITS(SAMPLE_W)) smp_if ();

  multi_tone_sine_synthesizer u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .smp_o   (smp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: register shadows, per-tone phase, quarter-wave table
  // --------------------------------------------------------------------------
  logic [COUNT_W-1:0] cfg_count;
  logic [STEP_W-1:0]  cfg_step [NUM_TONES];
  logic [31:0]        tone_phase [NUM_TONES];
  int                 sine_quarter [TABLE_LEN];

  // Pending restarts for the driver, expected samples for the monitor
  logic                       pending_restarts [$];
  logic signed [SAMPLE_W-1:0] expected_samples [$];

  int  err_cnt;
  bit  req_taken;     // request handshake seen at the last rising edge
  bit  smp_taken;     // sample handshake seen at the last rising edge
  bit  drv_idle_en;   // random gaps on the request side
  bit  snk_idle_en;   // random stalls on the sample side
  int  req_gap;
  int  smp_wait;

  // Quarter-wave entry i: amp * sin(pi/2 * (2i+1) / 2^(abits+1)), Q30 Taylor
  // series of 8 terms, rounded and clamped to 0 .. amp.
  function automatic int quarter_sine(input int unsigned idx);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      acc;
    longint      v;
    x    = (PI_Q30 * 64'(2 * idx + 1)) >> (TABLE_ADDR_BITS + 2);
    x2   = (x * x) >> 30;
    acc  = longint'(x);
    term = x;
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    v = (acc * AMP + (64'sd1 <<< 29)) >>> 30;
    if (v > AMP) begin
      v = AMP;
    end
    return int'(v);
  endfunction

  // One sample: read each active phase, then advance it by its step.
  // The mix is scaled by 0.999 (Q15) and divided by the active count,
  // rounding half away from zero on the magnitude.
  function automatic logic signed [SAMPLE_W-1:0] synth_next_sample(input logic restart);
    int unsigned                  active;
    longint                       mix;
    longint                       level;
    logic [63:0]                  mag;
    logic [63:0]                  denom;
    logic [63:0]                  q;
    logic [1:0]                   quad;
    logic [TABLE_ADDR_BITS-1:0]   addr;
    active = (cfg_count == 0) ? 1 : ((cfg_count > NUM_TONES) ? NUM_TONES : cfg_count);
    // restart clears inactive tones as well
    if (restart) begin
      for (int k = 0; k < NUM_TONES; k++) begin
        tone_phase[k] = '0;
      end
    end
    mix = 0;
    for (int k = 0; k < active; k++) begin
      quad = tone_phase[k][31:30];
      addr = tone_phase[k][29:30-TABLE_ADDR_BITS];
      if (quad[0]) begin
        addr = ~addr;   // mirrored quarter: last - addr
      end
      level = sine_quarter[addr];
      mix = quad[1] ? mix - level : mix + level;
      tone_phase[k] = tone_phase[k] + {1'b0, cfg_step[k]};
    end
    mag   = 64'((mix < 0) ? -mix : mix) * 64'(SCALE_Q15);
    denom = 64'(active) << 15;
    q     = (mag + denom / 2) / denom;
    if (q > 64'(AMP)) begin
      q = 64'(AMP);
    end
    return (mix < 0) ? SAMPLE_W'(-longint'(q)) : SAMPLE_W'(q);
  endfunction

  // --------------------------------------------------------------------------
  // Config writes: setup cycle, then access cycle; lands on the edge with
  // psel/penable/pwrite/pready all high. Shadow is updated at that edge.
  // --------------------------------------------------------------------------
  task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_TONE_COUNT) begin
      cfg_count = value[COUNT_W-1:0];
    end else if (idx >= REG_TONE_STEP_0 && idx <= REG_TONE_STEP_3) begin
      cfg_step[idx - REG_TONE_STEP_0] = value[STEP_W-1:0];
    end
    // anything past the list is dropped by the block
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Hold off until every queued request went in and every sample came back.
  task automatic wait_drained();
    while (pending_restarts.size() != 0 || req_if.valid || expected_samples.size() != 0)
      @(posedge clk_i);
  endtask

  // Queue n requests, restart flags taken LSB first from bits.
  task automatic queue_pattern(input logic [7:0] bits, input int n);
    for (int i = 0; i < n; i++) begin
      pending_restarts.push_back(bits[i]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Request driver: changes on the falling edge. The gap before an item only
  // counts down while the block is ready, so it lands after the busy window.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!req_if.valid || req_taken)) begin
      if (req_gap > 0) begin
        req_if.valid   <= 1'b0;
        req_if.restart <= 1'($urandom_range(0, 1));
        if (req_if.ready) begin
          req_gap <= req_gap - 1;
        end
      end else if (pending_restarts.size() != 0) begin
        req_if.restart <= pending_restarts.pop_front();
        req_if.valid   <= 1'b1;
        req_gap        <= drv_idle_en ? $urandom_range(0, 11) : 0;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Sample sink: after each sample draws a wait, counted once valid shows up.
  always @(negedge clk_i) begin
    int hold_cycles;
    if (rst_ni) begin
      if (smp_taken) begin
        hold_cycles = snk_idle_en ? $urandom_range(0, 11) : 0;
        smp_wait     <= hold_cycles;
        smp_if.ready <= (hold_cycles == 0);
      end else if (smp_if.valid && !smp_if.ready) begin
        if (smp_wait == 0) begin
          smp_if.ready <= 1'b1;
        end else begin
          smp_wait <= smp_wait - 1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: rising edge. Check an outgoing sample before booking the new
  // request so a stray sample can never match a fresh expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic signed [SAMPLE_W-1:0] want;
    req_taken <= rst_ni && req_if.valid && req_if.ready;
    smp_taken <= rst_ni && smp_if.valid && smp_if.ready;
    if (rst_ni && smp_if.valid && smp_if.ready) begin
      if (expected_samples.size() == 0) begin
        $error("sample: none expected, got %0d", smp_if.sample);
        err_cnt++;
      end else begin
        want = expected_samples.pop_front();
        if (smp_if.sample !== want) begin
          $error("sample: expected %0d, got %0d", want, smp_if.sample);
          err_cnt++;
        end
      end
    end
    if (rst_ni && req_if.valid && req_if.ready) begin
      expected_samples.push_back(synth_next_sample(req_if.restart));
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed phases first, then random configs with random items.
  // Each phase waits for a full drain, so the sender also pauses until all
  // samples are back before any register changes.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned    random_items;
    int unsigned    n;
    int unsigned    r;
    logic [31:0]    step_val;

    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    req_if.valid   = 1'b0;
    req_if.restart = 1'b0;
    smp_if.ready   = 1'b1;
    err_cnt        = 0;
    req_gap        = 0;
    smp_wait       = 0;
    drv_idle_en    = 1'b1;
    snk_idle_en    = 1'b1;
    random_items   = 0;

    cfg_count = COUNT_RESET;
    for (int k = 0; k < NUM_TONES; k++) begin
      cfg_step[k]   = STEP_RESET;
      tone_phase[k] = '0;
    end
    for (int i = 0; i < TABLE_LEN; i++) begin
      sine_quarter[i] = quarter_sine(i);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset config: one 1 kHz tone; restart first, then free running
    queue_pattern(8'b001, 3);
    wait_drained();

    // four tones at step extremes: min, max, zero, all ones (bit 31 dropped)
    set_reg(REG_TONE_COUNT, 32'hFFFF_FFFC);
    set_reg(REG_TONE_STEP_0, STEP_MIN);
    set_reg(REG_TONE_STEP_0 + 3'd1, STEP_MAX);
    set_reg(REG_TONE_STEP_0 + 3'd2, 32'd0);
    set_reg(REG_TONE_STEP_3, 32'hFFFF_FFFF);
    queue_pattern(8'b01000, 5);
    wait_drained();

    // count zero acts as one; tones 1..3 hold their phase
    set_reg(REG_TONE_COUNT, 32'd0);
    queue_pattern(8'b00, 2);
    wait_drained();

    // count above the tone number saturates; held tones resume
    set_reg(REG_TONE_COUNT, 32'd7);
    queue_pattern(8'b00, 2);
    wait_drained();

    // writes past the register list are dropped
    set_reg(REG_SPARE_FIRST, 32'hFFFF_FFFF);
    set_reg(REG_SPARE_FIRST + 3'd1, 32'h5555_5555);
    set_reg(REG_SPARE_FIRST + 3'd2, 32'hAAAA_AAAA);

    // restart with two active tones still clears the inactive ones
    set_reg(REG_TONE_COUNT, 32'd2);
    queue_pattern(8'b010, 3);
    wait_drained();
    set_reg(REG_TONE_COUNT, 32'd3);
    queue_pattern(8'b00, 2);
    wait_drained();

    // quarter-turn steps walk every quadrant and both table ends
    set_reg(REG_TONE_COUNT, 32'd5);
    for (int k = 0; k < NUM_TONES; k++) begin
      set_reg(REG_IDX_W'(REG_TONE_STEP_0 + k), 32'h4000_0000);
    end
    queue_pattern(8'b00000, 5);

    // random phases; some with no idling on one or both sides
    while (random_items < 375) begin
      wait_drained();
      drv_idle_en = ($urandom_range(0, 3) != 0);
      snk_idle_en = ($urandom_range(0, 3) != 0);

      r = $urandom_range(0, 9);
      if (r > 7) begin
        r = $urandom_range(1, 4);
      end
      set_reg(REG_TONE_COUNT, ($urandom() & 32'hFFFF_FFF8) | r);

      for (int k = 0; k < NUM_TONES; k++) begin
        if ($urandom_range(0, 1) == 1) begin
          case ($urandom_range(0, 7))
            0:       step_val = STEP_MIN;
            1:       step_val = STEP_MAX;
            2:       step_val = $urandom();
            default: step_val = $urandom_range(STEP_MIN, STEP_MAX)
                                | (32'($urandom_range(0, 1)) << 31);
          endcase
          set_reg(REG_IDX_W'(REG_TONE_STEP_0 + k), step_val);
        end
      end

      if ($urandom_range(0, 7) == 0) begin
        set_reg(REG_IDX_W'(REG_SPARE_FIRST + $urandom_range(0, 2)), $urandom());
      end

      n = $urandom_range(20, 45);
      for (int i = 0; i < n; i++) begin
        pending_restarts.push_back($urandom_range(0, 19) == 0);
      end
      random_items += n;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog: roughly ten times the slowest legal run
  initial begin
    #(5_000_000);
    $display("FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
sv/mts_pkg.sv
sv/mts_if.sv
sv/mts_sine_rom.sv
sv/multi_tone_sine_synthesizer.sv
bench/multi_tone_sine_synthesizer_tb.sv
